### src/fsp_pkg.sv
// Shared types, constants and helpers for the format specifier parser.
// Used by fsp_prefix_scan, fsp_result_build and format_specifier_parser_core.
`default_nettype none

package fsp_pkg;

  // numeric limits of width and precision accumulation
  localparam int unsigned NUMBER_BITS = 16;
  localparam int unsigned DEFAULT_PRECISION = 6;
  localparam longint unsigned RAW_LIMIT = (64'd1 << NUMBER_BITS) - 64'd1;
  localparam longint unsigned NUM_LIMIT = (RAW_LIMIT > 64'd65535) ? 64'd65535 : RAW_LIMIT;
  localparam logic [15:0] NUM_MAX = NUM_LIMIT[15:0];

  // parse phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_PREFIX = 2'd1;
  localparam logic [1:0] PH_MOD1   = 2'd2;
  localparam logic [1:0] PH_MOD2   = 2'd3;

  // precision scan phases
  localparam logic [1:0] PP_NODOT = 2'd0;
  localparam logic [1:0] PP_SIGN  = 2'd1;
  localparam logic [1:0] PP_DIGIT = 2'd2;
  localparam logic [1:0] PP_DONE  = 2'd3;

  // bits of the open-scan vector
  localparam int unsigned SO_ZERO  = 0;
  localparam int unsigned SO_PLUS  = 1;
  localparam int unsigned SO_MINUS = 2;
  localparam int unsigned SO_WFLAG = 3;
  localparam int unsigned SO_WDIG  = 4;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NUL = 8'h00;

  localparam int unsigned RESULT_BITS = 72;

  // prefix scan state
  typedef struct packed {
    logic        zero;
    logic        plus;
    logic        minus;
    logic        space;
    logic        hash;
    logic        dot;
    logic        neg;
    logic [4:0]  open;
    logic [15:0] width_acc;
    logic [15:0] prec_acc;
    logic [1:0]  prec_phase;
  } prefix_state_t;

  // whole parse state
  typedef struct packed {
    logic [1:0]    phase;
    prefix_state_t pre;
    logic [7:0]    conv;
    logic [7:0]    mod1;
    logic [7:0]    mod2;
    logic [7:0]    count;
  } parse_state_t;

  // one result item
  typedef struct packed {
    logic [7:0]  consumed;
    logic [16:0] precision_value;
    logic [15:0] field_width;
    logic        has_dot;
    logic        alt_form;
    logic        space_flag;
    logic        left_align;
    logic        plus_sign;
    logic        zero_pad;
    logic [7:0]  modifier_two;
    logic [7:0]  modifier_one;
    logic [7:0]  conversion;
  } result_t;

  localparam prefix_state_t PREFIX_CLEAR = '{
    zero: 1'b0, plus: 1'b0, minus: 1'b0, space: 1'b0, hash: 1'b0, dot: 1'b0,
    neg: 1'b0, open: 5'b11111, width_acc: 16'd0, prec_acc: 16'd0,
    prec_phase: PP_NODOT};

  localparam parse_state_t PARSE_CLEAR = '{
    phase: PH_IDLE, pre: PREFIX_CLEAR, conv: 8'd0, mod1: 8'd0, mod2: 8'd0,
    count: 8'd0};

  // accumulate one decimal digit with saturation
  function automatic logic [15:0] acc_digit(logic [15:0] acc, logic [3:0] d);
    logic [19:0] prod;
    prod = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {16'd0, d};
    if (prod > {4'd0, NUM_MAX}) begin
      return NUM_MAX;
    end
    return prod[15:0];
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // conversion and length letters
  function automatic logic is_letter(logic [7:0] c);
    logic hit;
    unique case (c) inside
      "d", "i", "u", "o", "l", "h", "x", "X", "f", "F", "L", "e", "E",
      "g", "G", "a", "A", "c", "s", "p", "n", "V", "W", "%": hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // prefix characters that are skipped
  function automatic logic is_skip(logic [7:0] c);
    return (c == " ") || (c == CH_TAB) || (c == ".") || is_digit(c) ||
           (c == "+") || (c == "-") || (c == "#");
  endfunction

  // bump with saturation at 255
  function automatic logic [7:0] bump(logic [7:0] n);
    return (n == 8'hFF) ? n : n + 8'd1;
  endfunction

endpackage

`default_nettype wire

### src/format_specifier_parser_core.sv
// Top level of the format specifier parser: input register, parse step, result register.
// Depends on fsp_pkg, fsp_prefix_scan and fsp_result_build.
`default_nettype none

// Takes the characters after a percent sign, one item each, with s_tuser high on
// the first one, and gives one result item per specifier: the conversion letter,
// up to two modifier characters, the flags, width, precision and character count.
// A result of all zeros marks an error. The block takes one character per cycle
// while the result side does not stall it; a result passes through the input
// register, then the result register. The rate is set by the parse state update,
// a loop through the state register holding one decimal multiply-accumulate per run.
// The input stalls only while a finished result waits downstream and the next
// character would give another result.
module format_specifier_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tuser,   // [0] start_req
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata    // [7:0] conversion, [15:8] modifier_one,
                                 // [23:16] modifier_two, [24] zero_pad,
                                 // [25] plus_sign, [26] left_align, [27] space_flag,
                                 // [28] alt_form, [29] has_dot, [45:30] field_width,
                                 // [62:46] precision_value, [70:63] consumed, [71] zero
);

  logic                  in_valid;
  logic [7:0]            in_ch;
  logic                  in_start;
  fsp_pkg::parse_state_t st;
  fsp_pkg::parse_state_t st_base;
  fsp_pkg::parse_state_t work;
  fsp_pkg::parse_state_t st_next;
  fsp_pkg::prefix_state_t pre_scan;
  fsp_pkg::result_t      res;
  logic                  emit;
  logic                  err;
  logic                  consume;
  logic                  out_valid;
  logic [71:0]           out_data;

  // input register
  assign consume  = in_valid && (!emit || !out_valid || m_tready);
  assign s_tready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_ch    <= s_tdata;
      in_start <= s_tuser;
    end
  end

  // start clears the running parse
  always_comb begin
    if (in_start) begin
      st_base       = fsp_pkg::PARSE_CLEAR;
      st_base.phase = fsp_pkg::PH_PREFIX;
    end else begin
      st_base = st;
    end
  end

  fsp_prefix_scan u_scan (
    .cur (st_base.pre),
    .c   (in_ch),
    .nxt (pre_scan)
  );

  // parse step for the held character
  always_comb begin
    work = st_base;
    emit = 1'b0;
    err  = 1'b0;
    unique case (st_base.phase)
      fsp_pkg::PH_PREFIX: begin
        if (in_ch == fsp_pkg::CH_NUL) begin
          emit = 1'b1;
          err  = 1'b1;
        end else if (fsp_pkg::is_skip(in_ch)) begin
          work.count = fsp_pkg::bump(st_base.count);
          work.pre   = pre_scan;
        end else if (!fsp_pkg::is_letter(in_ch)) begin
          emit = 1'b1;
          err  = 1'b1;
        end else begin
          work.conv  = in_ch;
          work.count = fsp_pkg::bump(st_base.count);
          if (in_ch == "l" || in_ch == "h" || in_ch == "L") begin
            work.phase = fsp_pkg::PH_MOD1;
          end else begin
            emit = 1'b1;
          end
        end
      end
      fsp_pkg::PH_MOD1: begin
        work.mod1 = in_ch;
        if (in_ch == fsp_pkg::CH_NUL) begin
          emit = 1'b1;
        end else begin
          work.count = fsp_pkg::bump(st_base.count);
          if ((st_base.conv == "l" && in_ch == "l") ||
              (st_base.conv == "h" && in_ch == "h")) begin
            work.phase = fsp_pkg::PH_MOD2;
          end else begin
            emit = 1'b1;
          end
        end
      end
      fsp_pkg::PH_MOD2: begin
        work.mod2 = in_ch;
        if (in_ch != fsp_pkg::CH_NUL) begin
          work.count = fsp_pkg::bump(st_base.count);
        end
        emit = 1'b1;
      end
      default: begin
        work = st_base;
      end
    endcase
  end

  assign st_next = emit ? fsp_pkg::PARSE_CLEAR : work;

  // parse state register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= fsp_pkg::PARSE_CLEAR;
    end else if (consume) begin
      st <= st_next;
    end
  end

  fsp_result_build u_build (
    .st  (work),
    .err (err),
    .res (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (consume && emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && emit) begin
      out_data <= {1'b0, res};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

`ifndef SYNTHESIS
  // second modifier only follows a doubled l or h
  a_mod2_letter: assert property (@(posedge clk) disable iff (rst)
    (st.phase == fsp_pkg::PH_MOD2) |-> ((st.conv == "l" || st.conv == "h") &&
                                       st.mod1 == st.conv))
    else $error("second modifier phase without ll or hh");

  // an idle parse holds no leftover count or letter
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (st.phase == fsp_pkg::PH_IDLE) |-> (st.count == 8'd0 && st.conv == 8'd0))
    else $error("idle parse keeps stale state");

  // an error result carries nothing else
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[7:0] == 8'd0) |-> (m_tdata == 72'd0))
    else $error("error result has nonzero fields");

  // a result follows only a consumed character
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(consume && emit))
    else $error("result appeared without a finishing character");
`endif

endmodule

`default_nettype wire

### src/fsp_prefix_scan.sv
// One step of the prefix scan: flags, width run and precision run.
// Depends on fsp_pkg.
`default_nettype none

module fsp_prefix_scan (
  input  fsp_pkg::prefix_state_t cur,
  input  logic [7:0]             c,
  output fsp_pkg::prefix_state_t nxt
);

  logic       sp;
  logic [3:0] d;

  assign sp = (c == " ") || (c == fsp_pkg::CH_TAB);
  assign d  = c[3:0];

  always_comb begin
    nxt = cur;

    // flags seen anywhere
    if (c == " ") nxt.space = 1'b1;
    if (c == "#") nxt.hash = 1'b1;

    // first qualifying character rules
    if (cur.open[fsp_pkg::SO_ZERO]) begin
      if (!(sp || c == "+" || c == "-" || c == "#")) begin
        if (c == "0") nxt.zero = 1'b1;
        nxt.open[fsp_pkg::SO_ZERO] = 1'b0;
      end
    end
    if (cur.open[fsp_pkg::SO_PLUS]) begin
      if (!(sp || c == "#" || c == "0" || c == "-")) begin
        if (c == "+") nxt.plus = 1'b1;
        nxt.open[fsp_pkg::SO_PLUS] = 1'b0;
      end
    end
    if (cur.open[fsp_pkg::SO_MINUS]) begin
      if (!(sp || c == "#" || c == "0" || c == "+")) begin
        if (c == "-") nxt.minus = 1'b1;
        nxt.open[fsp_pkg::SO_MINUS] = 1'b0;
      end
    end

    // width digit run
    if (cur.open[fsp_pkg::SO_WFLAG]) begin
      if (!(sp || c == "+" || c == "-" || c == "#" || c == "0")) begin
        nxt.open[fsp_pkg::SO_WFLAG] = 1'b0;
        if (c >= "1" && c <= "9") begin
          nxt.width_acc = fsp_pkg::acc_digit(16'd0, d);
        end else begin
          nxt.open[fsp_pkg::SO_WDIG] = 1'b0;
        end
      end
    end else if (cur.open[fsp_pkg::SO_WDIG]) begin
      if (fsp_pkg::is_digit(c)) begin
        nxt.width_acc = fsp_pkg::acc_digit(cur.width_acc, d);
      end else begin
        nxt.open[fsp_pkg::SO_WDIG] = 1'b0;
      end
    end

    // precision after the first dot
    case (cur.prec_phase)
      fsp_pkg::PP_NODOT: begin
        if (c == ".") begin
          nxt.dot = 1'b1;
          nxt.prec_phase = fsp_pkg::PP_SIGN;
        end
      end
      fsp_pkg::PP_SIGN: begin
        if (sp) begin
          nxt.prec_phase = fsp_pkg::PP_SIGN;
        end else if (c == "+" || c == "-") begin
          if (c == "-") nxt.neg = 1'b1;
          nxt.prec_phase = fsp_pkg::PP_DIGIT;
        end else if (fsp_pkg::is_digit(c)) begin
          nxt.prec_acc = fsp_pkg::acc_digit(cur.prec_acc, d);
          nxt.prec_phase = fsp_pkg::PP_DIGIT;
        end else begin
          nxt.prec_phase = fsp_pkg::PP_DONE;
        end
      end
      fsp_pkg::PP_DIGIT: begin
        if (fsp_pkg::is_digit(c)) begin
          nxt.prec_acc = fsp_pkg::acc_digit(cur.prec_acc, d);
        end else begin
          nxt.prec_phase = fsp_pkg::PP_DONE;
        end
      end
      default: begin
        nxt.prec_phase = cur.prec_phase;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/fsp_result_build.sv
// Builds one result item from the finished parse state, or the error item.
// Depends on fsp_pkg.
`default_nettype none

module fsp_result_build (
  input  fsp_pkg::parse_state_t st,
  input  logic                  err,
  output fsp_pkg::result_t      res
);

  logic        is_float;
  logic [16:0] prec;

  // default precision applies to the f, e, F and E conversions and to Lf and lf
  assign is_float = (st.conv == "f") || (st.conv == "e") || (st.conv == "F") ||
                    (st.conv == "E") ||
                    (((st.conv == "L") || (st.conv == "l")) && (st.mod1 == "f"));

  always_comb begin
    if (st.pre.dot) begin
      prec = st.pre.neg ? (17'd0 - {1'b0, st.pre.prec_acc}) : {1'b0, st.pre.prec_acc};
    end else if (is_float) begin
      prec = 17'(fsp_pkg::DEFAULT_PRECISION);
    end else begin
      prec = '1;
    end
  end

  always_comb begin
    if (err) begin
      res = '0;
    end else begin
      res.conversion      = st.conv;
      res.modifier_one    = st.mod1;
      res.modifier_two    = st.mod2;
      res.zero_pad        = st.pre.zero;
      res.plus_sign       = st.pre.plus;
      res.left_align      = st.pre.minus;
      res.space_flag      = st.pre.space;
      res.alt_form        = st.pre.hash;
      res.has_dot         = st.pre.dot;
      res.field_width     = st.pre.width_acc;
      res.precision_value = prec;
      res.consumed        = st.count;
    end
  end

endmodule

`default_nettype wire

### verif/format_specifier_parser_checker.sv
`timescale 1ns / 1ps
// Checker for the format specifier parser: follows both streams, predicts each result
// item from the accepted characters and compares it field by field, counting mismatches.
// Depends on fsp_pkg for the result layout, phase codes and numeric limits.
module format_specifier_parser_checker
  import fsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tuser,   // [0] start_req
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,   // result_t in [70:0], [71] zero
  output int          mismatches,
  output int          outstanding
);

  // predicted parse state
  logic [1:0]  stage;
  logic        f_zero, f_plus, f_minus, f_space, f_hash, f_dot, f_neg;
  logic [4:0]  open_scan;
  logic [15:0] width_acc;
  logic [15:0] prec_mag;
  logic [1:0]  prec_stage;
  logic [7:0]  letter, mod_a, mod_b, used;

  // specifiers predicted but not yet seen on the output
  result_t expected_specs[$];
  result_t got, want;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  // one decimal digit into a saturating accumulator
  function automatic logic [15:0] sat_digit(input logic [15:0] acc, input logic [7:0] c);
    int unsigned d;
    int unsigned lim;
    d = c - "0";
    lim = 32'(NUM_LIMIT);
    if (acc > (lim - d) / 10) begin
      return lim[15:0];
    end
    return 16'(acc * 10 + d);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got_v,
                             input logic [31:0] want_v);
    if (got_v !== want_v) begin
      report_mismatch($sformatf("%s got %0h expected %0h", name, got_v, want_v));
    end
  endtask

  task automatic clear_parse();
    stage = PH_IDLE;
    {f_zero, f_plus, f_minus, f_space, f_hash, f_dot, f_neg} = '0;
    open_scan = '1;
    width_acc = '0;
    prec_mag = '0;
    prec_stage = PP_NODOT;
    letter = '0;
    mod_a = '0;
    mod_b = '0;
    used = '0;
  endtask

  task automatic bump_used();
    if (used != 8'hFF) begin
      used++;
    end
  endtask

  // error: every field zero
  task automatic push_error();
    result_t r;
    r = '0;
    expected_specs.push_back(r);
    clear_parse();
  endtask

  task automatic push_result();
    result_t r;
    r = '0;
    r.conversion = letter;
    r.modifier_one = mod_a;
    r.modifier_two = mod_b;
    r.zero_pad = f_zero;
    r.plus_sign = f_plus;
    r.left_align = f_minus;
    r.space_flag = f_space;
    r.alt_form = f_hash;
    r.has_dot = f_dot;
    r.field_width = width_acc;
    // explicit precision, float default, or none
    if (f_dot) begin
      r.precision_value = {1'b0, prec_mag};
      if (f_neg) begin
        r.precision_value = -r.precision_value;
      end
    end else if (letter == "f" || letter == "e" || letter == "F" || letter == "E" ||
                 ((letter == "L" || letter == "l") && mod_a == "f")) begin
      r.precision_value = 17'(DEFAULT_PRECISION);
    end else begin
      r.precision_value = '1;
    end
    r.consumed = used;
    expected_specs.push_back(r);
    clear_parse();
  endtask

  // advance the predicted parse by one accepted character
  task automatic parse_char(input logic first, input logic [7:0] c);
    logic blank;
    logic hit;
    blank = (c == " ") || (c == CH_TAB);
    case (c)
      "d", "i", "u", "o", "l", "h", "x", "X", "f", "F", "L", "e", "E",
      "g", "G", "a", "A", "c", "s", "p", "n", "V", "W", "%": hit = 1'b1;
      default: hit = 1'b0;
    endcase
    if (first) begin
      clear_parse();
      stage = PH_PREFIX;
    end
    case (stage)
      PH_PREFIX: begin
        if (c == CH_NUL) begin
          push_error();
        end else if (blank || c == "." || is_dec(c) || c == "+" || c == "-" ||
                     c == "#") begin
          bump_used();
          if (c == " ") f_space = 1'b1;
          if (c == "#") f_hash = 1'b1;
          // each flag is decided by the first character outside its own skip set
          if (open_scan[SO_ZERO] && !(blank || c == "+" || c == "-" || c == "#")) begin
            f_zero = (c == "0");
            open_scan[SO_ZERO] = 1'b0;
          end
          if (open_scan[SO_PLUS] && !(blank || c == "#" || c == "0" || c == "-")) begin
            f_plus = (c == "+");
            open_scan[SO_PLUS] = 1'b0;
          end
          if (open_scan[SO_MINUS] && !(blank || c == "#" || c == "0" || c == "+")) begin
            f_minus = (c == "-");
            open_scan[SO_MINUS] = 1'b0;
          end
          // width: digit run starting at the first non-flag character
          if (open_scan[SO_WFLAG]) begin
            if (!(blank || c == "+" || c == "-" || c == "#" || c == "0")) begin
              open_scan[SO_WFLAG] = 1'b0;
              if (c >= "1" && c <= "9") begin
                width_acc = sat_digit(16'd0, c);
              end else begin
                open_scan[SO_WDIG] = 1'b0;
              end
            end
          end else if (open_scan[SO_WDIG]) begin
            if (is_dec(c)) begin
              width_acc = sat_digit(width_acc, c);
            end else begin
              open_scan[SO_WDIG] = 1'b0;
            end
          end
          // precision after the first dot
          case (prec_stage)
            PP_NODOT: begin
              if (c == ".") begin
                f_dot = 1'b1;
                prec_stage = PP_SIGN;
              end
            end
            PP_SIGN: begin
              if (c == "+" || c == "-") begin
                f_neg = (c == "-");
                prec_stage = PP_DIGIT;
              end else if (is_dec(c)) begin
                prec_mag = sat_digit(prec_mag, c);
                prec_stage = PP_DIGIT;
              end else if (!blank) begin
                prec_stage = PP_DONE;
              end
            end
            PP_DIGIT: begin
              if (is_dec(c)) begin
                prec_mag = sat_digit(prec_mag, c);
              end else begin
                prec_stage = PP_DONE;
              end
            end
            default: ;
          endcase
        end else if (!hit) begin
          push_error();
        end else begin
          letter = c;
          bump_used();
          if (c == "l" || c == "h" || c == "L") begin
            stage = PH_MOD1;
          end else begin
            push_result();
          end
        end
      end
      PH_MOD1: begin
        mod_a = c;
        if (c == CH_NUL) begin
          push_result();
        end else begin
          bump_used();
          if ((letter == "l" && c == "l") || (letter == "h" && c == "h")) begin
            stage = PH_MOD2;
          end else begin
            push_result();
          end
        end
      end
      PH_MOD2: begin
        mod_b = c;
        if (c != CH_NUL) bump_used();
        push_result();
      end
      default: ;
    endcase
  endtask

  // results first: a result never stems from a character taken at the same edge
  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      expected_specs.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_specs.size() == 0) begin
          report_mismatch("result item with none expected");
        end else begin
          got = m_tdata[70:0];
          want = expected_specs.pop_front();
          check_field("conversion", got.conversion, want.conversion);
          check_field("modifier_one", got.modifier_one, want.modifier_one);
          check_field("modifier_two", got.modifier_two, want.modifier_two);
          check_field("zero_pad", got.zero_pad, want.zero_pad);
          check_field("plus_sign", got.plus_sign, want.plus_sign);
          check_field("left_align", got.left_align, want.left_align);
          check_field("space_flag", got.space_flag, want.space_flag);
          check_field("alt_form", got.alt_form, want.alt_form);
          check_field("has_dot", got.has_dot, want.has_dot);
          check_field("field_width", got.field_width, want.field_width);
          check_field("precision_value", got.precision_value, want.precision_value);
          check_field("consumed", got.consumed, want.consumed);
          check_field("pad bit", m_tdata[71], 1'b0);
        end
      end
      if (s_tvalid && s_tready) begin
        parse_char(s_tuser, s_tdata);
      end
    end
    outstanding = expected_specs.size();
  end

endmodule

### verif/format_specifier_parser_core_test.sv
`timescale 1ns / 1ps
// Top of the format specifier parser testbench: clock, reset, character stimulus and
// result-side stalls, with the checker beside the block and the final verdict.
// Depends on fsp_pkg, format_specifier_parser_core and format_specifier_parser_checker.
module format_specifier_parser_core_test;
  import fsp_pkg::*;

  localparam int RANDOM_ITEMS  = 1400;
  localparam int RANDOM_PHASES = 7;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 10;
  localparam int LIMIT_NS      = 2000000;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;
  int          mismatches;
  int          outstanding;

  int          hold_ask = 0;
  bit          gaps_on;
  int          burst_left;
  logic [7:0]  spec_chars[$];
  string       conv_set = "diuolhxXfFLeEgGaAcspnVW%";

  always #5 clk = ~clk;

  format_specifier_parser_core uut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata
  );

  format_specifier_parser_checker spec_check (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .mismatches, .outstanding
  );

  // offer one character, called and left at a falling edge
  task automatic send_char(input logic first, input logic [7:0] c);
    if (gaps_on && burst_left == 0) begin
      s_tvalid <= 1'b0;
      s_tuser <= 1'($urandom);
      s_tdata <= 8'($urandom);
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end else if (burst_left > 0) begin
      burst_left--;
    end
    s_tvalid <= 1'b1;
    s_tuser <= first;
    s_tdata <= c;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) begin
      send_char(i == 0, txt[i]);
    end
  endtask

  // stop offering until every predicted result has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    s_tuser <= 1'($urandom);
    s_tdata <= 8'($urandom);
    do @(negedge clk); while (outstanding != 0);
  endtask

  function automatic logic [7:0] pick_prefix_char();
    case ($urandom_range(0, 9))
      0: return " ";
      1: return CH_TAB;
      2: return ".";
      3: return "+";
      4: return "-";
      5: return "#";
      6: return "0";
      default: return 8'("0" + $urandom_range(0, 9));
    endcase
  endfunction

  // length letters weighted up so the modifier paths get plenty of traffic
  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 9))
      0: return "l";
      1: return "h";
      2: return "L";
      default: return conv_set[$urandom_range(0, conv_set.len() - 1)];
    endcase
  endfunction

  function automatic logic [7:0] pick_modifier();
    case ($urandom_range(0, 7))
      0: return CH_NUL;
      1, 2: return 8'($urandom);
      default: return pick_letter();
    endcase
  endfunction

  // receiver: stretches of its own stall patterns, plus one long hold-off on request
  initial begin : rx_side
    int seen, mode, stretch, tick;
    seen = 0;
    mode = 0;
    stretch = 0;
    tick = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ask != seen) begin
        seen = hold_ask;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (stretch == 0) begin
          mode = $urandom_range(0, 3);
          stretch = $urandom_range(20, 200);
        end
        stretch--;
        tick++;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (tick % 4) != 3;
        endcase
      end
    end
  end

  // stimulus and verdict
  initial begin
    int items_sent, phase_goal, kind, plen;
    logic [7:0] lead, tail;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    gaps_on = 1'b1;
    burst_left = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed specifiers: flags, width, precision, modifiers, errors
    send_text("d");
    send_text("08.3f");
    send_text("-+ #12lld");
    send_text("hhx");
    send_text("Lf");
    send_text("lf");
    send_text("E");
    send_text(".-5e");
    send_text(". \t+99999s");
    send_text("99999999g");
    send_text("%");
    // bad character in the prefix
    send_text("5q");
    // end of string inside the prefix, and straight away
    send_text("12");
    send_char(1'b0, CH_NUL);
    send_char(1'b1, CH_NUL);
    // end of string read as a modifier
    send_text("l");
    send_char(1'b0, CH_NUL);
    send_text("hh");
    send_char(1'b0, CH_NUL);
    // any byte is taken as a modifier
    send_text("h");
    send_char(1'b0, 8'hFF);
    send_text("L");
    send_char(1'b0, 8'h80);
    // restart drops the open parse
    send_text("7.2");
    send_text("x");
    // a character while idle is ignored
    send_char(1'b0, "d");
    // long prefix saturates the character count
    send_char(1'b1, " ");
    repeat (299) send_char(1'b0, " ");
    send_char(1'b0, "d");
    drain_results();

    // random specifiers in phases with different idling
    items_sent = 0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      gaps_on = (p % 3) != 1;
      if (p == 2) hold_ask++;
      phase_goal = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_sent < phase_goal) begin
        kind = $urandom_range(0, 9);
        spec_chars.delete();
        if (kind == 9) begin
          // noise: random bytes with random start marks
          repeat ($urandom_range(1, 4)) begin
            send_char(1'($urandom_range(0, 1)), 8'($urandom));
            items_sent++;
          end
        end else begin
          plen = ($urandom_range(0, 15) == 0) ? $urandom_range(6, 14) : $urandom_range(0, 4);
          repeat (plen) spec_chars.push_back(pick_prefix_char());
          if (kind == 8) begin
            // broken: bad byte, end of string, or left open for the next start
            case ($urandom_range(0, 2))
              0: spec_chars.push_back(8'($urandom));
              1: spec_chars.push_back(CH_NUL);
              default: if (spec_chars.size() == 0) spec_chars.push_back(pick_prefix_char());
            endcase
          end else begin
            lead = pick_letter();
            spec_chars.push_back(lead);
            if (lead == "l" || lead == "h") begin
              tail = ($urandom_range(0, 1) == 0) ? lead : pick_modifier();
              spec_chars.push_back(tail);
              if (tail == lead) spec_chars.push_back(pick_modifier());
            end else if (lead == "L") begin
              spec_chars.push_back(($urandom_range(0, 2) == 0) ? 8'("f") : pick_modifier());
            end
          end
          foreach (spec_chars[i]) begin
            send_char(i == 0, spec_chars[i]);
          end
          items_sent += spec_chars.size();
          // stray character after a finished specifier
          if (kind < 8 && $urandom_range(0, 9) == 0) send_char(1'b0, 8'($urandom));
        end
      end
      if (p % 2 == 1) drain_results();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
